FILE: sv/wbd_pkg.sv
// Shared types and constants of the weighted block downsampler.
`timescale 1ns / 1ps
`default_nettype none

package wbd_pkg;

	// input item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 4'd1;

	// lane order inside the datapath
	localparam int NUM_LANES = 4;
	localparam int LANE_R    = 0;
	localparam int LANE_G    = 1;
	localparam int LANE_B    = 2;
	localparam int LANE_A    = 3;

	// Q1.15 by Q1.15 gives Q2.30; the byte is (255*S + 2^29) >> 30
	localparam int CHAN_W      = 16;
	localparam int PROD_W      = 32;
	localparam int FRAC_SHIFT  = 30;
	localparam int ROUND_BIT   = 29;
	localparam logic [7:0] BYTE_MAX = 8'hFF;

	// per-lane stage enables, driven by the top-level pipeline control
	typedef struct packed {
		logic ld_s1;    // pixel transfer: capture the channel
		logic ld_s2;    // product register takes stage 1
		logic acc_en;   // stage 2 product goes into the sum
		logic acc_last; // that product closes the block
		logic ld_s4;    // scaled sum register takes stage 3
	} wbd_lane_ctl_t;

endpackage

`default_nettype wire

FILE: sv/wbd_ifs.sv
// Stream and configuration channel interfaces of the weighted block downsampler.
`timescale 1ns / 1ps
`default_nettype none

interface wbd_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [5:0]  weight_index;
	logic [15:0] weight_value;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;
	logic [15:0] alpha;

	modport source (
		output valid, op, weight_index, weight_value, red, green, blue, alpha,
		input  ready
	);
	modport sink (
		input  valid, op, weight_index, weight_value, red, green, blue, alpha,
		output ready
	);
endinterface

interface wbd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] argb_pixel;

	modport source (output valid, argb_pixel, input ready);
	modport sink   (input valid, argb_pixel, output ready);
endinterface

interface wbd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wbd_pkg::CFG_IDX_W-1:0]  index;
	logic [wbd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/wbd_lane.sv
// One channel lane: weight multiply, block accumulator and scale by 255.
`timescale 1ns / 1ps
`default_nettype none

module wbd_lane #(
	parameter int SUM_W = 38
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wbd_pkg::wbd_lane_ctl_t        ctl,
	input  wire logic [wbd_pkg::CHAN_W-1:0]    chan,
	input  wire logic [wbd_pkg::CHAN_W-1:0]    weight_s1,
	output logic      [SUM_W+7:0]              scaled_s4
);

	logic [wbd_pkg::CHAN_W-1:0] chan_s1;
	logic [wbd_pkg::PROD_W-1:0] prod_s2;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           final_s3;
	logic [SUM_W-1:0]           total;

	assign total = sum_q + SUM_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			chan_s1 <= chan;
		end
		if (ctl.ld_s2) begin
			prod_s2 <= wbd_pkg::PROD_W'(chan_s1) * wbd_pkg::PROD_W'(weight_s1);
		end
		if (ctl.acc_en && ctl.acc_last) begin
			final_s3 <= total;
		end
		// 255*S as S*256 - S
		if (ctl.ld_s4) begin
			scaled_s4 <= {final_s3, 8'd0} - {8'd0, final_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.acc_en) begin
			sum_q <= ctl.acc_last ? '0 : total;
		end
	end

endmodule

`default_nettype wire

FILE: sv/wbd_merge.sv
// Merge stage: round and clamp the four lane sums, pack ARGB, hold the result.
`timescale 1ns / 1ps
`default_nettype none

module wbd_merge #(
	parameter int SC_W = 46
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [SC_W-1:0]   scaled [wbd_pkg::NUM_LANES],
	wbd_out_if.source              res
);

	logic [7:0] chan_byte [wbd_pkg::NUM_LANES];
	logic       out_valid_q;
	logic [31:0] argb_q;

	always_comb begin
		logic [SC_W-1:0] rounded;
		for (int k = 0; k < wbd_pkg::NUM_LANES; k++) begin
			rounded = scaled[k] + (SC_W'(1) << wbd_pkg::ROUND_BIT);
			if (|rounded[SC_W-1:wbd_pkg::FRAC_SHIFT+8]) begin
				chan_byte[k] = wbd_pkg::BYTE_MAX;
			end else begin
				chan_byte[k] = rounded[wbd_pkg::FRAC_SHIFT+7:wbd_pkg::FRAC_SHIFT];
			end
		end
	end

	assign in_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			argb_q <= {chan_byte[wbd_pkg::LANE_A], chan_byte[wbd_pkg::LANE_R],
			           chan_byte[wbd_pkg::LANE_G], chan_byte[wbd_pkg::LANE_B]};
		end
	end

	assign res.valid      = out_valid_q;
	assign res.argb_pixel = argb_q;

endmodule

`default_nettype wire

FILE: sv/weighted_block_downsampler.sv
// Top level of the weighted block downsampler: weight memory, lanes, merge stage.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                            Transfer
// pix       in   op, weight_index, weight_value, red/green/blue/alpha  valid & ready
// res       out  argb_pixel                                          valid & ready
// cfg       in   index (0 block_width, 1 block_height), data         valid & ready
//
// One input item per cycle while pix.ready is high. A pixel that closes a block
// raises res.valid through five registers: memory read at the transfer edge,
// multiply, accumulate, x255, merge.
// Weight loads write the memory at transfer and never enter the lanes.
// Reset clears sums, tap position and valids; block dims return to 1.
// Weight memory has no reset; load every slot a block uses first.
// Stages collapse bubbles. While a result waits on res, pixels that do not close
// a block keep flowing into the sums; a closing pixel waits in stage 2 until
// stage 3 frees, and input stalls behind it.

module weighted_block_downsampler #(
	parameter int MAX_BLOCK_DIM = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wbd_in_if.sink    pix,
	wbd_out_if.source res,
	wbd_cfg_if.sink   cfg
);

	localparam int TABLE_SIZE = MAX_BLOCK_DIM * MAX_BLOCK_DIM;
	localparam int TIDX_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int TAP_W      = $clog2(TABLE_SIZE + 1);
	localparam int DIM_W      = $clog2(MAX_BLOCK_DIM + 1);
	localparam int SUM_W      = wbd_pkg::PROD_W + $clog2(TABLE_SIZE);
	localparam int SC_W       = SUM_W + 8;
	localparam int WIX_W      = (TIDX_W > 6) ? TIDX_W : 6;

	// zero acts as one, anything above the maximum saturates
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [3:0] raw);
		logic [4:0] r5;
		r5 = {1'b0, raw};
		if (r5 == 5'd0) begin
			return DIM_W'(1);
		end else if (r5 > 5'(MAX_BLOCK_DIM)) begin
			return DIM_W'(MAX_BLOCK_DIM);
		end
		return DIM_W'(r5);
	endfunction

	// ---------------- configuration ----------------
	logic [3:0] block_width_q;
	logic [3:0] block_height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q  <= 4'd1;
			block_height_q <= 4'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				wbd_pkg::CFG_BLOCK_WIDTH:  block_width_q  <= cfg.data;
				wbd_pkg::CFG_BLOCK_HEIGHT: block_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	logic [DIM_W-1:0]   dim_w, dim_h;
	logic [2*DIM_W-1:0] taps_full;
	logic [TAP_W-1:0]   taps;

	assign dim_w     = clamp_dim(block_width_q);
	assign dim_h     = clamp_dim(block_height_q);
	assign taps_full = {{DIM_W{1'b0}}, dim_w} * {{DIM_W{1'b0}}, dim_h};
	assign taps      = TAP_W'(taps_full);

	// ---------------- pipeline control ----------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic last_s1, last_s2;
	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic adv2;
	logic merge_ready;

	// only a block-closing item needs a slot in stage 3; others retire into the sums
	assign ready_s4 = !valid_s4 || merge_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign adv2     = valid_s2 && (!last_s2 || ready_s3);
	assign ready_s2 = !valid_s2 || adv2;
	assign ready_s1 = !valid_s1 || ready_s2;

	logic accept, accept_pix, accept_load;

	assign pix.ready   = ready_s1;
	assign accept      = pix.valid && pix.ready;
	assign accept_pix  = accept && (pix.op == wbd_pkg::OP_PIXEL);
	assign accept_load = accept && (pix.op == wbd_pkg::OP_LOAD);

	// ---------------- tap position ----------------
	logic [TAP_W-1:0] tap_q;
	logic [TAP_W-1:0] tap_next;
	logic             last;

	assign tap_next = tap_q + 1'b1;
	// a shrunk block with the position already past it closes on the next pixel
	assign last     = (tap_next >= taps);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (accept_pix) begin
			tap_q <= last ? '0 : tap_next;
		end
	end

	// ---------------- weight memory ----------------
	logic [15:0]      weight_mem [TABLE_SIZE];
	logic [15:0]      weight_s1;
	logic [WIX_W-1:0] windex;
	logic             windex_ok;

	assign windex    = WIX_W'(pix.weight_index);
	assign windex_ok = (32'(pix.weight_index) < 32'(TABLE_SIZE));

	// a load lands at its transfer edge, before any later pixel reads, so no bypass needed
	always_ff @(posedge clk) begin
		if (accept_load && windex_ok) begin
			weight_mem[windex[TIDX_W-1:0]] <= pix.weight_value;
		end
		if (accept_pix) begin
			weight_s1 <= weight_mem[tap_q[TIDX_W-1:0]];
		end
	end

	// ---------------- stage valids ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= accept_pix;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= adv2 && last_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_pix) begin
			last_s1 <= last;
		end
		if (ready_s2 && valid_s1) begin
			last_s2 <= last_s1;
		end
	end

	// ---------------- lanes ----------------
	wbd_pkg::wbd_lane_ctl_t lane_ctl;

	assign lane_ctl.ld_s1    = accept_pix;
	assign lane_ctl.ld_s2    = ready_s2 && valid_s1;
	assign lane_ctl.acc_en   = adv2;
	assign lane_ctl.acc_last = last_s2;
	assign lane_ctl.ld_s4    = ready_s4 && valid_s3;

	logic [wbd_pkg::CHAN_W-1:0] lane_chan [wbd_pkg::NUM_LANES];
	logic [SC_W-1:0]            lane_scaled [wbd_pkg::NUM_LANES];

	assign lane_chan[wbd_pkg::LANE_R] = pix.red;
	assign lane_chan[wbd_pkg::LANE_G] = pix.green;
	assign lane_chan[wbd_pkg::LANE_B] = pix.blue;
	assign lane_chan[wbd_pkg::LANE_A] = pix.alpha;

	for (genvar g = 0; g < wbd_pkg::NUM_LANES; g++) begin : g_lane
		wbd_lane #(
			.SUM_W(SUM_W)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.chan     (lane_chan[g]),
			.weight_s1(weight_s1),
			.scaled_s4(lane_scaled[g])
		);
	end

	// ---------------- merge ----------------
	wbd_merge #(
		.SC_W(SC_W)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s4),
		.in_ready(merge_ready),
		.scaled  (lane_scaled),
		.res     (res)
	);

	// ---------------- assertions ----------------
	a_tap_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q < TAP_W'(TABLE_SIZE))
		else $error("tap position left the weight table");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_pix && last) |=> (tap_q == '0))
		else $error("tap position not cleared after closing pixel");

	a_pixel_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept_pix |=> valid_s1)
		else $error("transferred pixel missing from stage 1");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !ready_s3) |=> valid_s3)
		else $error("stalled block sum dropped");

endmodule

`default_nettype wire
